// ===== design/wmxh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmxh_pkg: shared types and constants for the word multiply-xor hash
// Hash constants, the sequencer state type, multiplier control and helpers.
// ----------------------------------------------------------------------------
package wmxh_pkg;

  localparam logic [63:0] SEED_VALUE       = 64'hcbf29ce484222325;
  localparam logic [63:0] STEP_MULTIPLIER  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] NONE_SUBSTITUTE  = 64'h00000100000001b3;
  localparam logic [63:0] FINAL_MULTIPLIER = 64'hD6E8FEB86659FD93;
  localparam int unsigned FINAL_SHIFT      = 32;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_NEXT
  } state_e;

  // Partial product selected in a multiplier pass
  typedef enum logic [1:0] {
    MUL_LL,
    MUL_HL,
    MUL_LH
  } mul_step_e;

  typedef struct packed {
    logic      en;
    mul_step_e step;
  } mul_ctl_t;

  // Keep the low byte_count bytes; counts of eight and above keep all
  function automatic logic [63:0] keep_low_bytes(input logic [63:0] word,
                                                 input logic [3:0]  count);
    logic [63:0] res;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      if (count[3] || (4'(i) < count)) begin
        res[i*8 +: 8] = word[i*8 +: 8];
      end
    end
    return res;
  endfunction

  // h ^ (h >> 32)
  function automatic logic [63:0] xor_shift(input logic [63:0] h);
    return h ^ (h >> FINAL_SHIFT);
  endfunction

endpackage

// ===== design/wmxh_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmxh_if: valid/ready channels of the word multiply-xor hash
// Message word input, hash result output and the configuration write channel.
// ----------------------------------------------------------------------------
interface wmxh_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last_word;

  modport source (output valid, output data_word, output byte_count,
                  output last_word, input ready);
  modport sink   (input valid, input data_word, input byte_count,
                  input last_word, output ready);
endinterface

interface wmxh_hash_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

interface wmxh_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/wmxh_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmxh_mul: shared 32x32 multiplier for 64-bit products mod 2^64
// Three passes: low x low into the product, then both cross terms into the
// upper half. Only the low 64 bits of the full product are kept.
// ----------------------------------------------------------------------------
module wmxh_mul (
  input  logic               clk_i,
  input  logic [63:0]        op_a_i,
  input  logic [63:0]        op_b_i,
  input  wmxh_pkg::mul_ctl_t ctl_i,
  output logic [63:0]        prod_o
);
  import wmxh_pkg::*;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [63:0] prod_q;

  // Operand halves for this pass
  always_comb begin
    case (ctl_i.step)
      MUL_HL: begin
        mul_a = op_a_i[63:32];
        mul_b = op_b_i[31:0];
      end
      MUL_LH: begin
        mul_a = op_a_i[31:0];
        mul_b = op_b_i[63:32];
      end
      default: begin
        mul_a = op_a_i[31:0];
        mul_b = op_b_i[31:0];
      end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  // Product register; cross terms land in the upper word
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      case (ctl_i.step) inside
        MUL_LL:         prod_q <= mul_p;
        MUL_HL, MUL_LH: prod_q[63:32] <= prod_q[63:32] + mul_p[31:0];
        default:        prod_q <= prod_q;
      endcase
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== design/word_multiply_xor_hash64.sv =====
`timescale 1ns / 1ps
// Sequence: a word with bytes is accepted in idle, then passes through the
// shared 32x32 multiplier, which builds each 64-bit product in three passes,
// and an update; a last word repeats the passes for the finalizer multiply.
// A new word is taken only in idle; an empty non-last word leaves it idle.
// Reset: accumulator loads the seed, reserved value clears to 0, output empty.
// ----------------------------------------------------------------------------
// word_multiply_xor_hash64: word-at-a-time multiply-xor hash, 64-bit result
// Absorbs masked message words into an accumulator and emits the avalanche-
// finalized hash on the last word, remapping the reserved none value.
// ----------------------------------------------------------------------------
module word_multiply_xor_hash64 (
  input  logic   clk_i,
  input  logic   rst_ni,
  wmxh_word_if.sink   in_i,
  wmxh_hash_if.source out_o,
  wmxh_cfg_if.sink    cfg_i
);
  import wmxh_pkg::*;

  state_e      state_q, state_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] opa_q, opa_d;
  logic        fin_q, fin_d;
  logic        last_q, last_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] hash_q, hash_d;
  logic [63:0] none_q;

  logic        in_accept;
  logic        out_load;
  logic        slot_free;
  logic [63:0] prod;
  logic [63:0] fin_hash;
  mul_ctl_t    mul_ctl;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_accept   = in_i.valid && in_i.ready;
  assign slot_free   = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid      = out_valid_q;
  assign out_o.hash_value = hash_q;

  // Shared multiplier
  wmxh_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (opa_q),
    .op_b_i (fin_q ? FINAL_MULTIPLIER : STEP_MULTIPLIER),
    .ctl_i  (mul_ctl),
    .prod_o (prod)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && ((in_i.byte_count != 4'd0) || in_i.last_word)) begin
          state_d = ST_M0;
        end
      end
      ST_M0: state_d = ST_M1;
      ST_M1: state_d = ST_M2;
      ST_M2: state_d = ST_NEXT;
      ST_NEXT: begin
        if (!fin_q) begin
          state_d = last_q ? ST_M0 : ST_IDLE;
        end else if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and control outputs
  assign fin_hash = xor_shift(prod);

  always_comb begin
    acc_d       = acc_q;
    opa_d       = opa_q;
    fin_d       = fin_q;
    last_d      = last_q;
    hash_d      = hash_q;
    out_load    = 1'b0;
    mul_ctl.en   = 1'b0;
    mul_ctl.step = MUL_LL;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          last_d = in_i.last_word;
          if (in_i.byte_count != 4'd0) begin
            opa_d = acc_q ^ keep_low_bytes(in_i.data_word, in_i.byte_count);
            fin_d = 1'b0;
          end else if (in_i.last_word) begin
            opa_d = xor_shift(acc_q);
            fin_d = 1'b1;
          end
        end
      end
      ST_M0: begin
        mul_ctl.en   = 1'b1;
        mul_ctl.step = MUL_LL;
      end
      ST_M1: begin
        mul_ctl.en   = 1'b1;
        mul_ctl.step = MUL_HL;
      end
      ST_M2: begin
        mul_ctl.en   = 1'b1;
        mul_ctl.step = MUL_LH;
      end
      ST_NEXT: begin
        if (!fin_q) begin
          acc_d = prod;
          if (last_q) begin
            opa_d = xor_shift(prod);
            fin_d = 1'b1;
          end
        end else if (slot_free) begin
          out_load = 1'b1;
          hash_d   = (fin_hash == none_q) ? NONE_SUBSTITUTE : fin_hash;
          acc_d    = SEED_VALUE;
        end
      end
      default: ;
    endcase
  end

  // Output slot
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= SEED_VALUE;
      fin_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      none_q      <= '0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      fin_q       <= fin_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        none_q <= cfg_i.data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    opa_q  <= opa_d;
    hash_q <= hash_d;
  end

`ifndef SYNTHESIS
  // An empty non-last word leaves the block idle with the accumulator intact
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_i.byte_count == 4'd0) && !in_i.last_word)
      |=> (state_q == ST_IDLE) && $stable(acc_q))
    else $error("empty word changed hash state");

  // Emitting a hash reloads the seed and fills the output slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (acc_q == SEED_VALUE) && out_valid_q)
    else $error("seed not reloaded after output");

  // The second cross-term pass (M2) follows the first (M1)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_M2) |-> ($past(state_q) == ST_M1))
    else $error("multiplier pass out of order");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the word multiply-xor hash
// Streams directed and random messages through the word channel and keeps a
// local model of the accumulator, finalizer and reserved-value remap. Each
// hash beat is checked against the oldest predicted digest. Phases vary the
// reserved value and the sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  import wmxh_pkg::*;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
  } msg_word_t;

  // Idle patterns, percent of cycles
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  localparam int DRAIN_CYCLES = 16;    // absorb and finalize, with margin
  localparam int PHASE_WORDS  = 350;

  logic clk_i;
  logic rst_ni;

  wmxh_word_if word_ch ();
  wmxh_hash_if hash_ch ();
  wmxh_cfg_if  cfg_ch ();

  word_multiply_xor_hash64 dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (word_ch),
    .out_o  (hash_ch),
    .cfg_i  (cfg_ch)
  );

  msg_word_t   pending_words[$];
  logic [63:0] hash_expected[$];
  logic [63:0] acc_model;
  logic [63:0] none_value_model;
  int          words_queued;
  int          words_accepted;
  int          error_count;
  int          sender_idle_pct;
  int          sink_stall_pct;
  logic        word_taken;
  logic        cfg_taken;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Absorb one masked word into an accumulator
  function automatic logic [63:0] fold_word(input logic [63:0] acc,
                                            input logic [63:0] word,
                                            input logic [3:0]  count);
    logic [63:0] mask;
    if (count >= 4'd8) mask = '1;
    else mask = (64'd1 << (8 * count)) - 64'd1;
    return (acc ^ (word & mask)) * STEP_MULTIPLIER;
  endfunction

  // Avalanche finalizer
  function automatic logic [63:0] mix_final(input logic [63:0] acc);
    logic [63:0] h;
    h = acc ^ (acc >> 32);
    h = h * FINAL_MULTIPLIER;
    return h ^ (h >> 32);
  endfunction

  // Update the model for one accepted word; returns 1 with the digest on a last word
  function automatic logic absorb_word(input logic [63:0] word, input logic [3:0] count,
                                       input logic last, output logic [63:0] digest);
    digest = '0;
    if (count != 4'd0) acc_model = fold_word(acc_model, word, count);
    if (!last) return 1'b0;
    digest = mix_final(acc_model);
    if (digest == none_value_model) digest = NONE_SUBSTITUTE;
    acc_model = SEED_VALUE;
    return 1'b1;
  endfunction

  // Monitor: observe beats on all channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin : monitor_proc
    logic [63:0] digest;
    if (!rst_ni) begin
      word_taken <= 1'b0;
      cfg_taken  <= 1'b0;
      acc_model = SEED_VALUE;
      none_value_model = '0;
    end else begin
      word_taken <= word_ch.valid && word_ch.ready;
      cfg_taken  <= cfg_ch.valid && cfg_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) none_value_model = cfg_ch.data;
      if (word_ch.valid && word_ch.ready) begin
        words_accepted++;
        if (absorb_word(word_ch.data_word, word_ch.byte_count, word_ch.last_word, digest))
          hash_expected.push_back(digest);
      end
      if (hash_ch.valid && hash_ch.ready) begin
        if (hash_expected.size() == 0) begin
          error_count++;
          $display("%0t: unexpected hash beat, expected none, actual %h",
                   $time, hash_ch.hash_value);
        end else begin
          digest = hash_expected.pop_front();
          if (hash_ch.hash_value !== digest) begin
            error_count++;
            $display("%0t: hash_value mismatch, expected %h, actual %h",
                     $time, digest, hash_ch.hash_value);
          end
        end
      end
    end
  end

  // Driver: word source and hash back-pressure, updated at the falling edge
  always @(negedge clk_i) begin : driver_proc
    msg_word_t w;
    if (!rst_ni) begin
      word_ch.valid <= 1'b0;
      hash_ch.ready <= 1'b0;
    end else begin
      if (!word_ch.valid || word_taken) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          w = pending_words.pop_front();
          word_ch.valid      <= 1'b1;
          word_ch.data_word  <= w.data;
          word_ch.byte_count <= w.count;
          word_ch.last_word  <= w.last;
        end else begin
          word_ch.valid <= 1'b0;
        end
      end
      hash_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic queue_word(input logic [63:0] data, input logic [3:0] count,
                            input logic last);
    msg_word_t w;
    w.data  = data;
    w.count = count;
    w.last  = last;
    pending_words.push_back(w);
    words_queued++;
  endtask

  function automatic logic [63:0] random_data();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return {$urandom(), $urandom()};
  endfunction

  // One message: mostly full words, some empty/short/oversized noise
  task automatic queue_message();
    int          n;
    int unsigned r;
    logic [3:0]  count;
    n = ($urandom_range(9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 20);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (i == n - 1) begin
        if (r < 8) count = 4'd0;
        else if (r < 16) count = 4'($urandom_range(9, 15));
        else count = 4'($urandom_range(1, 8));
      end else begin
        if (r < 88) count = 4'd8;
        else if (r < 92) count = 4'd0;
        else if (r < 96) count = 4'($urandom_range(1, 7));
        else count = 4'($urandom_range(9, 15));
      end
      queue_word(random_data(), count, i == n - 1);
    end
  endtask

  // Wait until every word is taken and every digest has come back
  task automatic wait_drained();
    while (words_accepted != words_queued || hash_expected.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_none_value(input logic [63:0] value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
      end
      IDLE_SENDER: begin
        sender_idle_pct = 58;
        sink_stall_pct  = 0;
      end
      IDLE_RECEIVER: begin
        sender_idle_pct = 0;
        sink_stall_pct  = 58;
      end
      default: begin
        sender_idle_pct = 12;
        sink_stall_pct  = 12;
      end
    endcase
  endtask

  // Stimulus
  initial begin : stimulus_proc
    logic [63:0] none_values[5];
    int          target;
    words_queued       = 0;
    words_accepted     = 0;
    error_count        = 0;
    sender_idle_pct    = 0;
    sink_stall_pct     = 0;
    word_ch.valid      = 1'b0;
    word_ch.data_word  = '0;
    word_ch.byte_count = '0;
    word_ch.last_word  = 1'b0;
    hash_ch.ready      = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;
    rst_ni             = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_none_value('0);

    // Directed: empty message, extremes, masking, oversized counts
    queue_word('1, 4'd0, 1'b1);
    queue_word('1, 4'd8, 1'b1);
    queue_word('0, 4'd8, 1'b1);
    for (int c = 1; c < 8; c++) queue_word('1, 4'(c), 1'b1);
    queue_word({$urandom(), $urandom()}, 4'd9, 1'b1);
    queue_word({$urandom(), $urandom()}, 4'd15, 1'b1);
    // empty word that is not last, then a full last word
    queue_word('1, 4'd0, 1'b0);
    queue_word('1, 4'd8, 1'b1);
    // short word that is not last, stream continues
    queue_word({$urandom(), $urandom()}, 4'd3, 1'b0);
    queue_word({$urandom(), $urandom()}, 4'd8, 1'b1);
    // multi-word message closed by an empty last word
    queue_word({$urandom(), $urandom()}, 4'd8, 1'b0);
    queue_word({$urandom(), $urandom()}, 4'd8, 1'b0);
    queue_word({$urandom(), $urandom()}, 4'd0, 1'b1);
    wait_drained();

    // Reserved value equal to the empty-message digest forces the remap
    write_none_value(mix_final(SEED_VALUE));
    queue_word('0, 4'd0, 1'b1);
    queue_word('1, 4'd8, 1'b1);
    wait_drained();

    // Random phases over reserved values and idle patterns
    none_values[0] = '1;
    none_values[1] = {$urandom(), $urandom()};
    none_values[2] = mix_final(SEED_VALUE);
    none_values[3] = '0;
    none_values[4] = {$urandom(), $urandom()};
    for (int p = 0; p < 5; p++) begin
      write_none_value(none_values[p]);
      set_idle(idle_mode_e'(p % 4));
      target = words_queued + PHASE_WORDS;
      while (words_queued < target) begin
        queue_message();
        // midway through phase 1 the sender holds off until all digests are back
        if (p == 1 && words_queued >= target - PHASE_WORDS / 2 &&
            words_queued < target - PHASE_WORDS / 2 + 20)
          wait_drained();
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Global time limit
  initial begin
    #4_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
